// ----- rtl/core/sacc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sacc_pkg: shared types and constants of the cache access classifier
// Geometry limits, register indexes, miss kind codes and queue entry type.
// ----------------------------------------------------------------------------
package sacc_pkg;

  localparam int MAX_SET_BITS_C         = 10;
  localparam int MAX_WAYS_C             = 8;
  localparam int MAX_BLOCK_WORDS_LOG2_C = 4;
  localparam logic [15:0] LFSR_SEED     = 16'hACE1;

  // Register indexes
  localparam logic [2:0] REG_BLOCK_WORDS_LOG2 = 3'd0;
  localparam logic [2:0] REG_SET_BITS         = 3'd1;
  localparam logic [2:0] REG_WAYS_LOG2        = 3'd2;
  localparam logic [2:0] REG_RANDOM_REPLACE   = 3'd3;
  localparam logic [2:0] REG_WRITE_BACK       = 3'd4;
  localparam logic [2:0] REG_WRITE_ALLOCATE   = 3'd5;

  // Miss kinds
  localparam logic [1:0] KIND_HIT        = 2'd0;
  localparam logic [1:0] KIND_COMPULSORY = 2'd1;
  localparam logic [1:0] KIND_CONFLICT   = 2'd2;
  localparam logic [1:0] KIND_CAPACITY   = 2'd3;

  // One access request handed from the front to the back
  typedef struct packed {
    logic        is_write;
    logic [31:0] address;
  } req_t;

endpackage : sacc_pkg
`default_nettype wire

// ----- rtl/core/set_assoc_cache_access_classifier_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_access_classifier_unit: cache access classifier top level
// Path: an input transfer passes the queue, then the row read and update;
// the row read coincides with the transfer out of the queue.
// A new access is taken only after the last one's row read and row write.
// Reset: synchronous; a clearing pass over all 2**MAX_SET_BITS sets sweeps the
// tag store before the first access is taken; configuration writes are taken.
// ----------------------------------------------------------------------------
module set_assoc_cache_access_classifier_unit #(
  parameter int MAX_SET_BITS         = sacc_pkg::MAX_SET_BITS_C,
  parameter int MAX_WAYS             = sacc_pkg::MAX_WAYS_C,
  parameter int MAX_BLOCK_WORDS_LOG2 = sacc_pkg::MAX_BLOCK_WORDS_LOG2_C
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // address
  input  wire logic        s_axis_tuser,  // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // hit, miss_kind[2], way_used[3],
                                          // words_fetched[5], words_written[5]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);
  import sacc_pkg::*;

  logic [2:0] bwl_r; logic [3:0] sb_r; logic [1:0] wl_r;
  logic rnd_r, wb_r, wa_r;
  req_t in_req, q_req;
  logic q_valid, q_ready;

  assign cfg_ready = 1'b1;
  assign in_req.is_write = s_axis_tuser;
  assign in_req.address  = s_axis_tdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bwl_r <= 3'd0; sb_r <= 4'd10; wl_r <= 2'd0;
      rnd_r <= 1'b0; wb_r <= 1'b1; wa_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BLOCK_WORDS_LOG2: bwl_r <= cfg_data[2:0];
        REG_SET_BITS:         sb_r  <= cfg_data;
        REG_WAYS_LOG2:        wl_r  <= cfg_data[1:0];
        REG_RANDOM_REPLACE:   rnd_r <= cfg_data[0];
        REG_WRITE_BACK:       wb_r  <= cfg_data[0];
        REG_WRITE_ALLOCATE:   wa_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sacc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  sacc_back #(
    .MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS),
    .MAX_BLOCK_WORDS_LOG2(MAX_BLOCK_WORDS_LOG2)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .cfg_bwl(bwl_r), .cfg_sb(sb_r), .cfg_wl(wl_r),
    .cfg_rnd(rnd_r), .cfg_wb(wb_r), .cfg_wa(wa_r),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(m_axis_tdata)
  );

endmodule : set_assoc_cache_access_classifier_unit
`default_nettype wire

// ----- rtl/core/sacc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sacc_front: input stage and request queue
// Takes input transfers into a two-entry queue that the back drains.
// ----------------------------------------------------------------------------
module sacc_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sacc_pkg::req_t in_req,
  output logic               q_valid,
  input  wire logic          q_ready,
  output sacc_pkg::req_t     q_req
);
  import sacc_pkg::*;

  req_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_req;
  end

endmodule : sacc_front
`default_nettype wire

// ----- rtl/core/sacc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sacc_back: tag lookup, replacement and state update
// Reads one set row, classifies the access, writes the row back.
// ----------------------------------------------------------------------------
module sacc_back #(
  parameter int MAX_SET_BITS         = sacc_pkg::MAX_SET_BITS_C,
  parameter int MAX_WAYS             = sacc_pkg::MAX_WAYS_C,
  parameter int MAX_BLOCK_WORDS_LOG2 = sacc_pkg::MAX_BLOCK_WORDS_LOG2_C
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  output logic                q_ready,
  input  wire sacc_pkg::req_t q_req,
  input  wire logic [2:0]     cfg_bwl,
  input  wire logic [3:0]     cfg_sb,
  input  wire logic [1:0]     cfg_wl,
  input  wire logic           cfg_rnd,
  input  wire logic           cfg_wb,
  input  wire logic           cfg_wa,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [15:0]         out_res
);
  import sacc_pkg::*;

  localparam int SETS  = 1 << MAX_SET_BITS;
  localparam int SW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int OBW   = $clog2(MAX_BLOCK_WORDS_LOG2 + 1) + 1;
  localparam int CW    = (SETS > 1) ? $clog2(SETS + 1) : 1;

  // One row holds every way of a set.
  typedef struct packed {
    logic [29:0] tag;
    logic        valid;
    logic        dirty;
    logic [2:0]  rank;
  } ent_t;
  typedef ent_t [MAX_WAYS-1:0] row_t;

  localparam logic [1:0] ST_CLR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_LOOK = 2'd2;

  row_t        mem [SETS];
  row_t        row_r;
  logic [1:0]  st_r, st_nxt;
  logic [CW-1:0] clr_r;
  req_t        req_r;
  logic [15:0] lfsr_r;
  logic        ov_r;
  logic [15:0] res_r;

  // Effective geometry.
  logic [OBW-1:0] ob;
  logic [4:0]     sb;
  logic [1:0]     wl;
  logic [4:0]     ways;
  logic [SW-1:0]  set_idx;
  logic [29:0]    tag;
  logic [31:0]    wa;

  always_comb begin
    ob = (cfg_bwl > 3'(MAX_BLOCK_WORDS_LOG2)) ? OBW'(MAX_BLOCK_WORDS_LOG2) : OBW'(cfg_bwl);
    sb = ({1'b0, cfg_sb} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS) : {1'b0, cfg_sb};
    wl = cfg_wl;
    if (wl == 2'd3 && MAX_WAYS < 8) wl = 2'd2;
    if (wl == 2'd2 && MAX_WAYS < 4) wl = 2'd1;
    if (wl == 2'd1 && MAX_WAYS < 2) wl = 2'd0;
    ways = 5'd1 << wl;
  end

  // Address split of the queue head (row read) and of the held request.
  function automatic logic [SW-1:0] set_of(logic [31:0] a, logic [OBW-1:0] o, logic [4:0] s);
    logic [31:0] w;
    w = a >> (7'd2 + 7'(o));
    return SW'(w & ((32'd1 << s) - 32'd1));
  endfunction

  assign set_idx = set_of(req_r.address, ob, sb);
  assign wa      = req_r.address >> (7'd2 + 7'(ob) + 7'(sb));
  assign tag     = wa[29:0];

  // Lookup over the row.
  logic          found, has_open;
  logic [WW-1:0] hw, ow, lw, w;
  logic [2:0]    best;
  logic [15:0]   lfsr_adv;
  logic          do_alloc, alloc, lfsr_step;
  logic          was_valid;
  logic [2:0]    r_old;
  logic [4:0]    bw, fetched, written;
  logic [1:0]    kind;
  row_t          nrow;

  always_comb begin
    found = 1'b0; has_open = 1'b0; hw = '0; ow = '0; lw = '0; best = 3'd0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (5'(i) < ways) begin
        if (row_r[i].valid && row_r[i].tag == tag && !found) begin
          found = 1'b1; hw = WW'(i);
        end
        if (!row_r[i].valid && !has_open) begin
          has_open = 1'b1; ow = WW'(i);
        end
        if (row_r[i].rank > best) begin
          best = row_r[i].rank; lw = WW'(i);
        end
      end
    end
    lfsr_adv = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[15:1]};
    alloc    = !req_r.is_write || cfg_wb || cfg_wa;
    do_alloc = !found && alloc;
    lfsr_step = 1'b0;
    if (found) w = hw;
    else if (has_open) w = ow;
    else if (ways == 5'd1) w = '0;
    else if (cfg_rnd) begin
      w = WW'(lfsr_adv[WW-1:0] & WW'(ways - 5'd1));
      lfsr_step = do_alloc;
    end else w = lw;
    bw = 5'd1 << ob;
    kind = found ? KIND_HIT : (has_open ? KIND_COMPULSORY
                             : ((ways == 5'd1) ? KIND_CONFLICT : KIND_CAPACITY));
    was_valid = row_r[w].valid;
    fetched = 5'd0; written = 5'd0;
    nrow = row_r;
    if (found) begin
      if (req_r.is_write) begin
        if (cfg_wb) nrow[w].dirty = 1'b1;
        else written = 5'd1;
      end
    end else if (!alloc) begin
      written = 5'd1;
    end else begin
      if (was_valid && row_r[w].dirty) written = bw;
      if (req_r.is_write && !cfg_wb) begin
        fetched = (bw > 5'd1) ? bw : 5'd0;
        written = written + 5'd1;
      end else fetched = bw;
      nrow[w].tag   = tag;
      nrow[w].valid = 1'b1;
      nrow[w].dirty = req_r.is_write && cfg_wb;
    end
    // Recency update of the touched way.
    r_old = was_valid ? row_r[w].rank : 3'd7;
    if (found || do_alloc) begin
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (5'(i) < ways && WW'(i) != w && row_r[i].valid && row_r[i].rank < r_old)
          nrow[i].rank = row_r[i].rank + 3'd1;
      end
      nrow[w].rank = 3'd0;
    end
  end

  // A new request may enter while the held result leaves in the same cycle.
  assign q_ready   = (st_r == ST_IDLE) && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign out_res   = res_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLR:  if (clr_r == CW'(SETS - 1)) st_nxt = ST_IDLE;
      ST_IDLE: if (q_valid && q_ready) st_nxt = ST_LOOK;
      ST_LOOK: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLR;
      clr_r  <= '0;
      lfsr_r <= LFSR_SEED;
      ov_r   <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLR) clr_r <= clr_r + CW'(1);
      if (st_r == ST_LOOK) begin
        ov_r <= 1'b1;
        if (lfsr_step) lfsr_r <= lfsr_adv;
      end else if (out_ready) ov_r <= 1'b0;
    end
  end

  // Row memory: clearing pass, registered read, write-back of the row.
  always_ff @(posedge clk) begin
    if (st_r == ST_CLR) mem[clr_r[SW-1:0]] <= '0;
    else if (st_r == ST_LOOK) mem[set_idx] <= nrow;
    if (st_r == ST_IDLE) row_r <= mem[set_of(q_req.address, ob, sb)];
    if (q_valid && q_ready) req_r <= q_req;
    if (st_r == ST_LOOK)
      res_r <= {written, fetched, (found || do_alloc) ? 3'(w) : 3'd0, kind, found};
  end

endmodule : sacc_back
`default_nettype wire
